// File: rtl/armed_command_line_recognizer_macros.svh
// Assertion macros for the armed command line recognizer checker.
// Depends on nothing; included by the checker file.
`ifndef ARMED_COMMAND_LINE_RECOGNIZER_MACROS_SVH
`define ARMED_COMMAND_LINE_RECOGNIZER_MACROS_SVH

// clocked assertion, off while reset is held
`define ACLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define ACLR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/aclr_pkg.sv
// Shared types and constants of the armed command line recognizer.
// Used by the front, queue, back, top level and checker.
package aclr_pkg;

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_TICK = 2'd1,
    MODE_OVF  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    RESP_PONG      = 4'd0,
    RESP_STATUS    = 4'd1,
    RESP_OK_ARM    = 4'd2,
    RESP_ERR_ARM   = 4'd3,
    RESP_OK_START  = 4'd4,
    RESP_ERR_START = 4'd5,
    RESP_OK_LINE   = 4'd6,
    RESP_ERR_LINE  = 4'd7,
    RESP_OK_LAP    = 4'd8,
    RESP_ERR_LAP   = 4'd9,
    RESP_KEEP      = 4'd10,
    RESP_OK_STOP   = 4'd11,
    RESP_ERR_CMD   = 4'd12,
    RESP_ERR_LONG  = 4'd13,
    RESP_ERR_RX    = 4'd14
  } resp_t;

  typedef enum logic [3:0] {
    CMD_PING, CMD_STATUS, CMD_ARM, CMD_START, CMD_LINE, CMD_LAP,
    CMD_KEEP, CMD_STOP, CMD_UNKNOWN, CMD_LONG, CMD_TICK, CMD_OVF
  } cmd_t;

  typedef enum logic [3:0] {
    KW_PING, KW_STATUS, KW_ARM, KW_START, KW_LINE, KW_LAP, KW_KEEP, KW_K, KW_STOP
  } kw_t;

  localparam int KW_COUNT = 9;
  localparam int KW_CHARS = 6;

  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "PING  ", "STATUS", "ARM   ", "START ", "LINE  ", "LAP   ", "KEEP  ", "K     ",
    "STOP  "
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd6, 3'd3, 3'd5, 3'd4, 3'd3, 3'd4, 3'd1, 3'd4
  };

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;

  localparam logic [15:0] ARM_WINDOW_RESET = 16'd5000;
  localparam int          ELAPSED_W        = 17;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic       request_accepted;
  } aclr_in_t;

  typedef struct packed {
    logic [3:0] response;
    logic       armed_now;
  } aclr_out_t;

  typedef struct packed {
    cmd_t cmd;
    logic accepted;
  } aclr_cmd_t;

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [8*KW_CHARS-1:0] t;
    logic [7:0] c;
    t = KW_TEXT[k];
    case (pos)
      3'd0:    c = t[47:40];
      3'd1:    c = t[39:32];
      3'd2:    c = t[31:24];
      3'd3:    c = t[23:16];
      3'd4:    c = t[15:8];
      default: c = t[7:0];
    endcase
    return c;
  endfunction

  function automatic cmd_t kw_to_cmd(input kw_t k);
    cmd_t c;
    case (k)
      KW_PING:   c = CMD_PING;
      KW_STATUS: c = CMD_STATUS;
      KW_ARM:    c = CMD_ARM;
      KW_START:  c = CMD_START;
      KW_LINE:   c = CMD_LINE;
      KW_LAP:    c = CMD_LAP;
      KW_KEEP:   c = CMD_KEEP;
      KW_K:      c = CMD_KEEP;
      KW_STOP:   c = CMD_STOP;
      default:   c = CMD_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/aclr_queue.sv
// Short command queue between the front and the back of the recognizer.
// Depends on aclr_pkg for the command type and depth.
module aclr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  aclr_pkg::aclr_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output aclr_pkg::aclr_cmd_t head_data
);
  import aclr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  aclr_cmd_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/aclr_front.sv
// Front of the recognizer: takes items, folds case, tracks the line and
// narrows the keyword candidates as characters arrive. Depends on aclr_pkg.
module aclr_front #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  aclr_pkg::aclr_in_t  in_data,
  output logic                push,
  output aclr_pkg::aclr_cmd_t push_data
);
  import aclr_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY);

  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                discard_r, discard_nxt;
  logic                plus_r, plus_nxt;
  logic [KW_COUNT-1:0] cand_r, cand_nxt;

  logic [7:0]          folded;
  logic                printable;
  logic [KW_COUNT-1:0] step_ok;
  logic                hit;
  kw_t                 hit_k;

  always_comb begin
    folded    = (in_data.rx_byte >= CHAR_LO_A && in_data.rx_byte <= CHAR_LO_Z) ?
                (in_data.rx_byte - CASE_DELTA) : in_data.rx_byte;
    printable = (folded >= PRINT_LO) && (folded <= PRINT_HI);

    for (int k = 0; k < KW_COUNT; k++) begin
      step_ok[k] = cand_r[k] && (len_r < LEN_W'(KW_LEN[k])) &&
                   (folded == kw_char(k, len_r[2:0]));
    end

    hit   = 1'b0;
    hit_k = KW_PING;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand_r[k] && (len_r == LEN_W'(KW_LEN[k]))) begin
        hit   = 1'b1;
        hit_k = kw_t'(4'(k));
      end
    end

    len_nxt     = len_r;
    discard_nxt = discard_r;
    plus_nxt    = plus_r;
    cand_nxt    = cand_r;
    push        = 1'b0;
    push_data   = '{cmd: CMD_TICK, accepted: in_data.request_accepted};

    if (in_fire) begin
      case (in_data.mode)
        MODE_BYTE: begin
          if (in_data.rx_byte == CHAR_CR || in_data.rx_byte == CHAR_LF) begin
            if (len_r != '0) begin
              if (discard_r) begin
                push           = 1'b1;
                push_data.cmd  = CMD_LONG;
              end else if (hit) begin
                push           = 1'b1;
                push_data.cmd  = kw_to_cmd(hit_k);
              end else if (!plus_r) begin
                push           = 1'b1;
                push_data.cmd  = CMD_UNKNOWN;
              end
            end
            len_nxt     = '0;
            discard_nxt = 1'b0;
            cand_nxt    = '1;
          end else if (printable && !discard_r) begin
            if (len_r >= LEN_W'(LINE_CAPACITY - 1)) begin
              discard_nxt = 1'b1;
            end else begin
              len_nxt  = LEN_W'(len_r + 1'b1);
              cand_nxt = step_ok;
              if (len_r == '0) begin
                plus_nxt = (folded == CHAR_PLUS);
              end
            end
          end
        end
        MODE_TICK: begin
          push = 1'b1;
        end
        MODE_OVF: begin
          len_nxt       = '0;
          discard_nxt   = 1'b0;
          cand_nxt      = '1;
          push          = 1'b1;
          push_data.cmd = CMD_OVF;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      discard_r <= 1'b0;
      plus_r    <= 1'b0;
      cand_r    <= '1;
    end else begin
      len_r     <= len_nxt;
      discard_r <= discard_nxt;
      plus_r    <= plus_nxt;
      cand_r    <= cand_nxt;
    end
  end

endmodule

// File: rtl/aclr_back.sv
// Back of the recognizer: runs queued commands against the arm state and
// the elapsed counter, and holds the result register. Depends on aclr_pkg.
module aclr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                head_valid,
  input  aclr_pkg::aclr_cmd_t head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output aclr_pkg::aclr_out_t out_data
);
  import aclr_pkg::*;

  logic [15:0]          window_r;
  logic                 armed_r, armed_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 out_valid_r, out_valid_nxt;
  aclr_out_t            out_r, out_nxt;

  logic                 in_window;
  logic                 emit;
  resp_t                resp;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    pop           = head_valid && (!out_valid_r || !out_stall);
    armed_nxt     = armed_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    emit          = 1'b0;
    resp          = RESP_ERR_CMD;
    in_window     = armed_r && (elapsed_r <= {1'b0, window_r});

    if (pop) begin
      case (head_data.cmd)
        CMD_TICK: begin
          if (elapsed_r != ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
          if (armed_r && (elapsed_nxt > {1'b0, window_r})) begin
            armed_nxt = 1'b0;
          end
        end
        CMD_OVF: begin
          emit = 1'b1;
          resp = RESP_ERR_RX;
        end
        CMD_PING: begin
          emit = 1'b1;
          resp = RESP_PONG;
        end
        CMD_STATUS: begin
          emit = 1'b1;
          resp = RESP_STATUS;
        end
        CMD_ARM: begin
          emit        = 1'b1;
          resp        = RESP_OK_ARM;
          armed_nxt   = 1'b1;
          elapsed_nxt = '0;
        end
        CMD_START: begin
          emit      = 1'b1;
          armed_nxt = 1'b0;
          resp      = !in_window ? RESP_ERR_ARM :
                      (head_data.accepted ? RESP_OK_START : RESP_ERR_START);
        end
        CMD_LINE: begin
          emit      = 1'b1;
          armed_nxt = 1'b0;
          resp      = !in_window ? RESP_ERR_ARM :
                      (head_data.accepted ? RESP_OK_LINE : RESP_ERR_LINE);
        end
        CMD_LAP: begin
          emit      = 1'b1;
          armed_nxt = 1'b0;
          resp      = !in_window ? RESP_ERR_ARM :
                      (head_data.accepted ? RESP_OK_LAP : RESP_ERR_LAP);
        end
        CMD_KEEP: begin
          emit = 1'b1;
          resp = RESP_KEEP;
        end
        CMD_STOP: begin
          emit      = 1'b1;
          resp      = RESP_OK_STOP;
          armed_nxt = 1'b0;
        end
        CMD_LONG: begin
          emit = 1'b1;
          resp = RESP_ERR_LONG;
        end
        default: begin
          emit = 1'b1;
          resp = RESP_ERR_CMD;
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt     = 1'b1;
      out_nxt.response  = resp;
      out_nxt.armed_now = armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= ARM_WINDOW_RESET;
      armed_r     <= 1'b0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_data;
      end
      armed_r     <= armed_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// File: rtl/armed_command_line_recognizer.sv
// Top level of the armed command line recognizer.
// Depends on aclr_pkg, aclr_front, aclr_queue and aclr_back.
//
// Items (received bytes, millisecond ticks, overflow events) are taken one
// per cycle while the two-entry command queue has room; a byte is matched
// against the keyword table as it arrives, so a line end needs no scan of
// stored characters. The back retires one queued command per cycle
// whenever the result register is free or being taken, and a response
// passes through the command queue and the result register after the line
// end or overflow that causes it. Ticks, stored characters, empty lines
// and lines starting with '+' that do not overflow the line give no
// response. arm_window_ms is written through cfg_* at any time the block
// is idle; cfg_ready is always high.
module armed_command_line_recognizer #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aclr_pkg::aclr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aclr_pkg::aclr_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import aclr_pkg::*;

  logic      in_fire;
  logic      q_push, q_full, q_pop, q_head_valid;
  aclr_cmd_t q_push_data, q_head_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_fire   = in_valid && !q_full;

  aclr_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .push     (q_push),
    .push_data(q_push_data)
  );

  aclr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_data (q_head_data)
  );

  aclr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .head_valid(q_head_valid),
    .head_data (q_head_data),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/aclr_checker.sv
// Port-level checks of the armed command line recognizer, bound to the top.
// Depends on aclr_pkg and armed_command_line_recognizer_macros.svh.
`include "armed_command_line_recognizer_macros.svh"

module aclr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input aclr_pkg::aclr_out_t out_data
);
  import aclr_pkg::*;

  logic out_held;
  logic arm_code;
  logic disarm_code;

  assign out_held    = out_valid && out_stall;
  assign arm_code    = (out_data.response == RESP_OK_ARM);
  assign disarm_code = (out_data.response == RESP_ERR_ARM) ||
                       (out_data.response == RESP_OK_START) ||
                       (out_data.response == RESP_ERR_START) ||
                       (out_data.response == RESP_OK_LINE) ||
                       (out_data.response == RESP_ERR_LINE) ||
                       (out_data.response == RESP_OK_LAP) ||
                       (out_data.response == RESP_ERR_LAP) ||
                       (out_data.response == RESP_OK_STOP);

  `ACLR_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `ACLR_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_data), "stalled result changed")
  `ACLR_ASSERT(a_code_range, out_valid |-> out_data.response <= RESP_ERR_RX, "bad response code")
  `ACLR_ASSERT(a_arm_flag, out_valid && arm_code |-> out_data.armed_now, "OK ARM unarmed")
  `ACLR_ASSERT(a_disarm, out_valid && disarm_code |-> !out_data.armed_now, "arm flag kept")

endmodule

bind armed_command_line_recognizer aclr_checker u_aclr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
